@@ rtl/core/xed_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xed_pkg: shared types and tables for the XML entity decoder
// Entity spellings, replacement characters, match-state codes and the
// job record passed from the front classifier to the back expander.
// ----------------------------------------------------------------------------
package xed_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0] AMP_CHAR = 8'h26;

  // match state: idle, '&' seen, then per-entity partial prefixes
  localparam logic [3:0] MP_IDLE = 4'd0;
  localparam logic [3:0] MP_AMP  = 4'd1;

  typedef logic [3:0] mpos_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] ent;
    logic [2:0] cnt;   // letters of the entity name already matched
  } ent_pos_t;

  // One input's worth of output: optional '&'+prefix flush, optional single
  // byte, optional trailing '&'.
  typedef struct packed {
    logic       flush_en;
    logic [1:0] ent;
    logic [2:0] cnt;
    logic       lit_en;
    logic [7:0] lit;
    logic       tail_en;
    logic       last;
  } job_t;

  function automatic logic [7:0] ent_letter(input logic [1:0] e, input logic [2:0] i);
    logic [7:0] c;
    c = 8'h00;
    unique case (e)
      2'd0: begin
        unique case (i)
          3'd0:    c = "a";
          3'd1:    c = "m";
          3'd2:    c = "p";
          3'd3:    c = ";";
          default: c = 8'h00;
        endcase
      end
      2'd1: begin
        unique case (i)
          3'd0:    c = "q";
          3'd1:    c = "u";
          3'd2:    c = "o";
          3'd3:    c = "t";
          3'd4:    c = ";";
          default: c = 8'h00;
        endcase
      end
      2'd2: begin
        unique case (i)
          3'd0:    c = "l";
          3'd1:    c = "t";
          3'd2:    c = ";";
          default: c = 8'h00;
        endcase
      end
      default: begin
        unique case (i)
          3'd0:    c = "g";
          3'd1:    c = "t";
          3'd2:    c = ";";
          default: c = 8'h00;
        endcase
      end
    endcase
    return c;
  endfunction

  function automatic logic [7:0] ent_char(input logic [1:0] e);
    logic [7:0] c;
    unique case (e)
      2'd0:    c = 8'h26;
      2'd1:    c = 8'h22;
      2'd2:    c = 8'h3C;
      default: c = 8'h3E;
    endcase
    return c;
  endfunction

  function automatic mpos_t ent_base(input logic [1:0] e);
    mpos_t b;
    unique case (e)
      2'd0:    b = 4'd2;
      2'd1:    b = 4'd5;
      2'd2:    b = 4'd9;
      default: b = 4'd11;
    endcase
    return b;
  endfunction

  function automatic logic [2:0] ent_len(input logic [1:0] e);
    logic [2:0] l;
    unique case (e)
      2'd0:    l = 3'd4;
      2'd1:    l = 3'd5;
      default: l = 3'd3;
    endcase
    return l;
  endfunction

  function automatic ent_pos_t ent_decode(input mpos_t s);
    ent_pos_t p;
    p = '0;
    unique case (s)
      4'd2, 4'd3, 4'd4: begin
        p.valid = 1'b1; p.ent = 2'd0; p.cnt = 3'(s - 4'd1);
      end
      4'd5, 4'd6, 4'd7, 4'd8: begin
        p.valid = 1'b1; p.ent = 2'd1; p.cnt = 3'(s - 4'd4);
      end
      4'd9, 4'd10: begin
        p.valid = 1'b1; p.ent = 2'd2; p.cnt = 3'(s - 4'd8);
      end
      4'd11, 4'd12: begin
        p.valid = 1'b1; p.ent = 2'd3; p.cnt = 3'(s - 4'd10);
      end
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

@@ rtl/core/xed_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xed_front: input classifier
// Tracks the partial-entity match state and turns each accepted byte into
// a job record; inputs that only advance a match push nothing.
// ----------------------------------------------------------------------------
module xed_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_byte,
  input  logic          in_message_end,
  input  logic          queue_full,
  output logic          job_push,
  output xed_pkg::job_t job
);

  xed_pkg::mpos_t    mpos_r, mpos_nxt, s_new;
  xed_pkg::ent_pos_t cur, nd;
  logic              accept, fresh, adv, hit;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;
  assign cur      = xed_pkg::ent_decode(mpos_r);

  always_comb begin
    job   = '0;
    s_new = xed_pkg::MP_IDLE;
    fresh = 1'b0;
    adv   = 1'b0;
    hit   = 1'b0;
    job.last = in_message_end;
    if (mpos_r == xed_pkg::MP_AMP) begin
      for (int e = 0; e < 4; e++) begin
        if (!hit && in_byte == xed_pkg::ent_letter(2'(e), 3'd0)) begin
          hit   = 1'b1;
          s_new = xed_pkg::ent_base(2'(e));
        end
      end
      if (hit) begin
        adv = 1'b1;
      end else begin
        job.flush_en = 1'b1;   // bare '&'
        fresh        = 1'b1;
      end
    end else if (cur.valid) begin
      if (in_byte == xed_pkg::ent_letter(cur.ent, cur.cnt)) begin
        if (3'(cur.cnt + 3'd1) == xed_pkg::ent_len(cur.ent)) begin
          job.lit_en = 1'b1;
          job.lit    = xed_pkg::ent_char(cur.ent);
        end else begin
          s_new = 4'(mpos_r + 4'd1);
          adv   = 1'b1;
        end
      end else begin
        job.flush_en = 1'b1;
        job.ent      = cur.ent;
        job.cnt      = cur.cnt;
        fresh        = 1'b1;
      end
    end else begin
      fresh = 1'b1;
    end

    if (fresh) begin
      if (in_byte == xed_pkg::AMP_CHAR) begin
        if (in_message_end) begin
          job.tail_en = 1'b1;
        end else begin
          s_new = xed_pkg::MP_AMP;
        end
      end else begin
        job.lit_en = 1'b1;
        job.lit    = in_byte;
      end
    end

    // message end with a partial entity still open: replay it literally
    nd = xed_pkg::ent_decode(s_new);
    if (adv && in_message_end) begin
      job.flush_en = 1'b1;
      job.ent      = nd.ent;
      job.cnt      = nd.cnt;
      s_new        = xed_pkg::MP_IDLE;
    end
  end

  assign job_push = accept && (job.flush_en || job.lit_en || job.tail_en);
  assign mpos_nxt = accept ? s_new : mpos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mpos_r <= xed_pkg::MP_IDLE;
    end else begin
      mpos_r <= mpos_nxt;
    end
  end

endmodule

@@ rtl/core/xed_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xed_queue: job FIFO
// Small register FIFO decoupling the classifier from the expander.
// ----------------------------------------------------------------------------
module xed_queue #(
  parameter int unsigned DEPTH = xed_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  xed_pkg::job_t din,
  input  logic          pop,
  output xed_pkg::job_t dout,
  output logic          full,
  output logic          empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  xed_pkg::job_t  mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign dout  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_r + 1'b1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_r + 1'b1);
    end
    if (push && !pop) begin
      count_nxt = CW'(count_r + 1'b1);
    end else if (pop && !push) begin
      count_nxt = CW'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

@@ rtl/core/xed_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xed_back: job expander and output register
// Walks the head job one byte per cycle into the output register while out_ready does not stall it.
// ----------------------------------------------------------------------------
module xed_back (
  input  logic          clk,
  input  logic          rst_n,
  input  xed_pkg::job_t job,
  input  logic          empty,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          out_run_end,
  output logic          out_message_end
);

  logic [2:0] pos_r, pos_nxt;
  logic [2:0] flen, njob;
  logic       emit, is_last;
  logic [7:0] sel_byte;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r;
  logic       run_end_r, msg_end_r;

  assign flen    = job.flush_en ? 3'(job.cnt + 3'd1) : 3'd0;
  assign njob    = 3'(flen + {2'b00, job.lit_en} + {2'b00, job.tail_en});
  assign is_last = (pos_r == 3'(njob - 3'd1));
  assign emit    = !empty && (!out_valid_r || out_ready);
  assign pop     = emit && is_last;

  always_comb begin
    if (pos_r < flen) begin
      sel_byte = (pos_r == 3'd0) ? xed_pkg::AMP_CHAR
                                 : xed_pkg::ent_letter(job.ent, 3'(pos_r - 3'd1));
    end else if (job.lit_en && pos_r == flen) begin
      sel_byte = job.lit;
    end else begin
      sel_byte = xed_pkg::AMP_CHAR;
    end
  end

  always_comb begin
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r;
    if (emit) begin
      pos_nxt       = is_last ? 3'd0 : 3'(pos_r + 3'd1);
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r <= sel_byte;
      run_end_r  <= is_last;
      msg_end_r  <= is_last && job.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_run_end     = run_end_r;
  assign out_message_end = msg_end_r;

endmodule

@@ rtl/core/xml_entity_decoder_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xml_entity_decoder_top: XML character entity decoder
// Replaces &amp; &quot; &lt; &gt; in a byte stream by & " < >.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready): one text byte per request, with
//    in_message_end on the last byte of a message.
//  - Output channel (out_valid/out_ready): one decoded byte per request.
//    out_run_end marks the last byte caused by an input request and
//    out_message_end the final byte of a message.
//  - An input yields 0..6 output bytes. Bytes that only extend a partial
//    entity yield none; a broken prefix is replayed as literal bytes.
//  - Path: an accepted input is registered in the job queue, then expanded
//    from there into the output register.
//  - Throughput: one input per cycle while in_ready is high, one output
//    byte per cycle while out_ready is high; while the expander works off
//    an input's results, the job queue (QUEUE_DEPTH entries) absorbs further inputs.
//  - Reset (rst_n low, synchronous) clears the match state, the queue and
//    the output valid; no clearing pass is needed.
//  - When out_ready is low the output byte holds; the queue fills and
//    then in_ready drops until the expander moves again.
// ----------------------------------------------------------------------------
module xml_entity_decoder_top #(
  parameter int unsigned QUEUE_DEPTH = xed_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_message_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_run_end,
  output logic       out_message_end
);

  xed_pkg::job_t push_job, head_job;
  logic          job_push, job_pop, q_full, q_empty;

  // front: match state and classification
  xed_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .in_message_end (in_message_end),
    .queue_full     (q_full),
    .job_push       (job_push),
    .job            (push_job)
  );

  // decoupling queue between classifier and expander
  xed_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .din   (push_job),
    .pop   (job_pop),
    .dout  (head_job),
    .full  (q_full),
    .empty (q_empty)
  );

  // back: byte-by-byte expansion into the output register
  xed_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .job             (head_job),
    .empty           (q_empty),
    .pop             (job_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_run_end     (out_run_end),
    .out_message_end (out_message_end)
  );

endmodule

@@ rtl/core/xed_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xed_checker: port-level assertions for the entity decoder
// Watches the top-level ports; attached by bind.
// ----------------------------------------------------------------------------
module xed_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] in_byte,
  input logic       in_message_end,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_run_end,
  input logic       out_message_end
);

  // output register is empty right after reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // a message end byte always closes its run
  a_msg_end_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_message_end || out_run_end))
    else $error("out_message_end without out_run_end");

  // a run is streamed without gaps
  a_run_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_run_end |=> out_valid)
    else $error("gap inside an output run");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte)
      && $stable(out_run_end) && $stable(out_message_end))
    else $error("stalled output changed");

  // a waiting input request holds its payload
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_byte)
      && $stable(in_message_end))
    else $error("stalled input changed");

endmodule

bind xml_entity_decoder_top xed_checker u_xed_checker (.*);

@@ bench/xml_entity_decoder_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xml_entity_decoder_checker: decode predictor and result scoreboard
// Watches both request channels of the entity decoder, predicts the decoded
// bytes of every accepted input and compares them in order with the output.
// ----------------------------------------------------------------------------
module xml_entity_decoder_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              in_message_end,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [7:0]        out_byte,
  input  logic              out_run_end,
  input  logic              out_message_end,
  output int unsigned       fail_count,
  output int unsigned       pending_results
);

  typedef enum logic [1:0] {ENT_AMP, ENT_QUOT, ENT_LT, ENT_GT} entity_e;

  localparam xed_pkg::mpos_t MP_AMP_FIRST  = 4'd2;
  localparam xed_pkg::mpos_t MP_QUOT_FIRST = 4'd5;
  localparam xed_pkg::mpos_t MP_LT_FIRST   = 4'd9;
  localparam xed_pkg::mpos_t MP_GT_FIRST   = 4'd11;
  localparam int unsigned    MAX_RUN       = 6;
  localparam int unsigned    REPORT_LIMIT  = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       run_end;
    logic       msg_end;
  } dec_byte_t;

  dec_byte_t      expected_bytes[$];
  xed_pkg::mpos_t match_pos;
  logic [7:0]     run_buf[MAX_RUN];
  int unsigned    run_len;

  initial begin
    fail_count      = 0;
    pending_results = 0;
    match_pos       = xed_pkg::MP_IDLE;
  end

  function automatic string entity_name(input entity_e e);
    case (e)
      ENT_AMP:  return "amp;";
      ENT_QUOT: return "quot;";
      ENT_LT:   return "lt;";
      default:  return "gt;";
    endcase
  endfunction

  function automatic xed_pkg::mpos_t entity_first(input entity_e e);
    case (e)
      ENT_AMP:  return MP_AMP_FIRST;
      ENT_QUOT: return MP_QUOT_FIRST;
      ENT_LT:   return MP_LT_FIRST;
      default:  return MP_GT_FIRST;
    endcase
  endfunction

  function automatic logic [7:0] entity_glyph(input entity_e e);
    case (e)
      ENT_AMP:  return "&";
      ENT_QUOT: return "\"";
      ENT_LT:   return "<";
      default:  return ">";
    endcase
  endfunction

  // Which entity a partial state belongs to, and how many letters are matched.
  function automatic logic partial_entity(input xed_pkg::mpos_t s, output entity_e e,
                                          output int unsigned cnt);
    int    k;
    int    first;
    string name;
    e   = ENT_AMP;
    cnt = 0;
    for (k = 0; k < 4; k++) begin
      first = int'(entity_first(entity_e'(k)));
      name  = entity_name(entity_e'(k));
      if (int'(s) >= first && int'(s) < first + name.len() - 1) begin
        e   = entity_e'(k);
        cnt = int'(s) - first + 1;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void emit(input logic [7:0] b);
    if (run_len < MAX_RUN) begin
      run_buf[run_len] = b;
      run_len++;
    end
  endfunction

  // '&' plus the letters matched so far
  function automatic void replay_prefix(input xed_pkg::mpos_t s);
    entity_e     e;
    int unsigned cnt;
    int unsigned i;
    string       name;
    emit(xed_pkg::AMP_CHAR);
    if (partial_entity(s, e, cnt)) begin
      name = entity_name(e);
      for (i = 0; i < cnt; i++) emit(name[i]);
    end
  endfunction

  function automatic void decode_step(input logic [7:0] b, input logic last);
    xed_pkg::mpos_t s;
    entity_e        e;
    int unsigned    cnt;
    int             k;
    int unsigned    i;
    logic           fresh;
    logic           hit;
    string          name;
    dec_byte_t      item;
    s       = match_pos;
    fresh   = 1'b0;
    run_len = 0;
    if (s == xed_pkg::MP_AMP) begin
      hit = 1'b0;
      for (k = 0; k < 4 && !hit; k++) begin
        name = entity_name(entity_e'(k));
        if (b == name[0]) begin
          s   = entity_first(entity_e'(k));
          hit = 1'b1;
        end
      end
      if (!hit) begin
        emit(xed_pkg::AMP_CHAR);
        s     = xed_pkg::MP_IDLE;
        fresh = 1'b1;
      end
    end else if (partial_entity(s, e, cnt)) begin
      name = entity_name(e);
      if (b == name[cnt]) begin
        if (cnt + 1 == name.len()) begin
          emit(entity_glyph(e));
          s = xed_pkg::MP_IDLE;
        end else begin
          s = s + 4'd1;
        end
      end else begin
        replay_prefix(s);
        s     = xed_pkg::MP_IDLE;
        fresh = 1'b1;
      end
    end else begin
      s     = xed_pkg::MP_IDLE;
      fresh = 1'b1;
    end

    // breaking byte is looked at again as plain text
    if (fresh) begin
      if (b == xed_pkg::AMP_CHAR) s = xed_pkg::MP_AMP;
      else emit(b);
    end

    if (last && s != xed_pkg::MP_IDLE) begin
      replay_prefix(s);
      s = xed_pkg::MP_IDLE;
    end
    match_pos = s;

    for (i = 0; i < run_len; i++) begin
      item.data    = run_buf[i];
      item.run_end = (i == run_len - 1);
      item.msg_end = last && (i == run_len - 1);
      expected_bytes.push_back(item);
    end
  endfunction

  task automatic log_mismatch(input logic have_want, input dec_byte_t want,
                              input dec_byte_t got);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) begin
      if (have_want)
        $display("%0t: output mismatch: expected byte %02h run_end %0b msg_end %0b, got byte %02h run_end %0b msg_end %0b",
                 $realtime, want.data, want.run_end, want.msg_end,
                 got.data, got.run_end, got.msg_end);
      else
        $display("%0t: unexpected output: byte %02h run_end %0b msg_end %0b",
                 $realtime, got.data, got.run_end, got.msg_end);
    end
  endtask

  always @(posedge clk) begin
    dec_byte_t got;
    dec_byte_t want;
    if (!rst_n) begin
      match_pos = xed_pkg::MP_IDLE;
      expected_bytes.delete();
    end else begin
      if (out_valid && out_ready) begin
        got.data    = out_byte;
        got.run_end = out_run_end;
        got.msg_end = out_message_end;
        if (expected_bytes.size() == 0) begin
          want = '0;
          log_mismatch(1'b0, want, got);
        end else begin
          want = expected_bytes.pop_front();
          if (got !== want) log_mismatch(1'b1, want, got);
        end
      end
      if (in_valid && in_ready) decode_step(in_byte, in_message_end);
    end
    pending_results = expected_bytes.size();
  end

endmodule

@@ bench/xml_entity_decoder_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xml_entity_decoder_top_tb: stimulus and verdict for the entity decoder
// Sends directed entity cases, then random messages mixing whole entities,
// broken prefixes, bare ampersands and plain bytes under several idle and
// stall patterns. A side checker predicts and compares every output byte.
// ----------------------------------------------------------------------------
module xml_entity_decoder_top_tb;

  // Run bounds. Worst case is far below the limit: ~410 requests, each up
  // to six output bytes, each byte behind a long receiver stall.
  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned ITEMS_PER_PHASE = 88;
  localparam int unsigned SETTLE_CYCLES   = 20;
  localparam int unsigned RESET_CYCLES    = 12;

  logic       clk            = 1'b0;
  logic       rst_n          = 1'b0;
  logic       in_valid       = 1'b0;
  logic [7:0] in_byte        = 8'h00;
  logic       in_message_end = 1'b0;
  logic       out_ready      = 1'b0;
  wire        in_ready;
  wire        out_valid;
  wire  [7:0] out_byte;
  wire        out_run_end;
  wire        out_message_end;

  int unsigned fail_count;
  int unsigned pending_results;
  int unsigned cycle_count    = 0;
  int unsigned items_sent     = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  string      entity_names[4] = '{"amp;", "quot;", "lt;", "gt;"};
  logic [7:0] text[$];   // bytes of the message being built

  xml_entity_decoder_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte         (in_byte),
    .in_message_end  (in_message_end),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_run_end     (out_run_end),
    .out_message_end (out_message_end)
  );

  xml_entity_decoder_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte         (in_byte),
    .in_message_end  (in_message_end),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_run_end     (out_run_end),
    .out_message_end (out_message_end),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the decoder hangs or drops output.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("xml_entity_decoder_top_tb: errors");
      $finish;
    end
  end

  // Receiver back-pressure, redrawn every cycle at the falling edge.
  always @(negedge clk) begin
    out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  // One input request. Called at a falling edge, returns at a falling edge
  // with valid still high, so the next call never toggles valid twice in
  // one step.
  task automatic send_byte(input logic [7:0] value, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_byte        <= value;
    in_message_end <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // Sends the built message; the end marker rides on its final byte.
  task automatic send_text();
    int i;
    for (i = 0; i < text.size(); i++) send_byte(text[i], i == text.size() - 1);
    text.delete();
  endtask

  // Drop valid and hold off until every predicted byte has come out.
  // Always waits for a falling edge first so valid is not raised in the same step.
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_results != 0) @(negedge clk);
  endtask

  // '&' followed by the first `cut` letters of an entity name
  function automatic void add_entity(input string name, input int cut);
    int i;
    text.push_back(xed_pkg::AMP_CHAR);
    for (i = 0; i < cut; i++) text.push_back(name[i]);
  endfunction

  // Plain byte, biased toward entity letters so that near-misses happen often.
  function automatic logic [7:0] pick_byte();
    string letters;
    letters = "&amlpqugto;";
    if ($urandom_range(3) == 0) return letters[$urandom_range(letters.len() - 1)];
    return 8'($urandom_range(255));
  endfunction

  // Random message: well-formed entities (the most common token), plus broken prefixes,
  // lone ampersands and arbitrary bytes.
  function automatic void build_message();
    int    tokens;
    int    kind;
    string name;
    tokens = $urandom_range(1, 8);
    repeat (tokens) begin
      kind = $urandom_range(99);
      name = entity_names[$urandom_range(3)];
      if (kind < 45) begin
        add_entity(name, name.len());
      end else if (kind < 65) begin
        // partial prefix, often followed by a breaking byte
        add_entity(name, $urandom_range(name.len() - 1));
        if ($urandom_range(1) == 1) text.push_back(pick_byte());
      end else if (kind < 72) begin
        text.push_back(xed_pkg::AMP_CHAR);
      end else begin
        text.push_back(pick_byte());
      end
    end
  endfunction

  initial begin
    int          phase;
    int unsigned target;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: byte range ends including zero, each entity whole,
    // a bare ampersand before an entity, and a broken prefix that
    // ends the message on an ampersand (both flushed literally).
    text.push_back(8'h01);
    text.push_back(8'hFF);
    text.push_back(8'h00);
    send_text();
    add_entity("gt;", 3);
    send_text();
    add_entity("quot;", 5);
    send_text();
    add_entity("amp;", 4);
    send_text();
    text.push_back(xed_pkg::AMP_CHAR);
    add_entity("lt;", 3);
    send_text();
    add_entity("gt;", 1);
    text.push_back(xed_pkg::AMP_CHAR);
    send_text();
    drain();

    // Random phases: free flow, sender gaps, receiver stalls, both.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      target = items_sent + ITEMS_PER_PHASE;
      while (items_sent < target) begin
        build_message();
        send_text();
      end
      drain();
    end

    // Extra cycles to catch any stray output after the last expected byte.
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("xml_entity_decoder_top_tb: clean");
    end else begin
      $display("xml_entity_decoder_top_tb: errors");
    end
    $finish;
  end

endmodule
